// ----- rtl/core/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and the pipeline control word of the unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int unsigned CoordWidth     = 16;
  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned OutWidth       = 16;
  localparam int unsigned NumLanes       = 3;

  // control word that travels beside the data of every stage
  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [NumLanes-1:0] neg;
  } ctl_t;

endpackage

// ----- rtl/core/tun_norm_step.sv -----
// ----------------------------------------------------------------------------
// tun_norm_step
// One registered step of the quotient search: decides bit K of the three
// normal magnitudes by comparing remainder against (2q + 2^K) * 2^K * S.
// ----------------------------------------------------------------------------
module tun_norm_step #(
  parameter int unsigned SW  = 70,
  parameter int unsigned QW  = 15,
  parameter int unsigned RW  = 100,
  parameter int unsigned QSW = 86,
  parameter int unsigned K   = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  tun_pkg::ctl_t                      ctl_i,
  input  logic [SW-1:0]                      sum_i,
  input  logic [tun_pkg::NumLanes-1:0][RW-1:0]  rem_i,
  input  logic [tun_pkg::NumLanes-1:0][QSW-1:0] acc_i,
  input  logic [tun_pkg::NumLanes-1:0][QW-1:0]  quo_i,
  output tun_pkg::ctl_t                      ctl_o,
  output logic [SW-1:0]                      sum_o,
  output logic [tun_pkg::NumLanes-1:0][RW-1:0]  rem_o,
  output logic [tun_pkg::NumLanes-1:0][QSW-1:0] acc_o,
  output logic [tun_pkg::NumLanes-1:0][QW-1:0]  quo_o
);

  tun_pkg::ctl_t                             ctl_q;
  logic [SW-1:0]                             sum_q;
  logic [tun_pkg::NumLanes-1:0][RW-1:0]      rem_d, rem_q;
  logic [tun_pkg::NumLanes-1:0][QSW-1:0]     acc_d, acc_q;
  logic [tun_pkg::NumLanes-1:0][QW-1:0]      quo_d, quo_q;
  logic [tun_pkg::NumLanes-1:0][RW-1:0]      dlt;

  always_comb begin
    for (int l = 0; l < tun_pkg::NumLanes; l++) begin
      dlt[l]   = (RW'(acc_i[l]) << (K + 1)) + (RW'(sum_i) << (2 * K));
      rem_d[l] = rem_i[l];
      acc_d[l] = acc_i[l];
      quo_d[l] = quo_i[l];
      // keep the trial bit when the square still fits under the target
      if (dlt[l] <= rem_i[l]) begin
        rem_d[l] = rem_i[l] - dlt[l];
        acc_d[l] = acc_i[l] + (QSW'(sum_i) << K);
        quo_d[l] = quo_i[l] | (QW'(1) << K);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_i;
      rem_q <= rem_d;
      acc_q <= acc_d;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign sum_o = sum_q;
  assign rem_o = rem_q;
  assign acc_o = acc_q;
  assign quo_o = quo_q;

endmodule

// ----- rtl/core/triangle_unit_normal_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit
// Unit face normal of a triangle in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Input stream: one triangle per transaction, nine coordinates in tdata
// (vertex zero, pivot vertex, vertex two; x, y, z each). Output stream: one
// normal per transaction, x/y/z in tdata and the degenerate flag in tuser.
// A new triangle can be taken every cycle while the receiver does not stall;
// the pipeline has six stages for edges, cross product, squares and sum, one
// stage per quotient bit of the bit-by-bit search, and one output stage.
// Edges and cross product are exact; each component is c * 2^F divided by
// the length of c, truncated toward zero, found without any divider or
// square root unit.
// A zero-length cross product gives a zero vector with tuser high.
// Reset clears all valid bits; no transaction is in flight afterward.
// When the receiver stalls, the whole pipeline holds and s_axis_tready_o
// drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_unit_normal_unit #(
  parameter int unsigned COORD_WIDTH      = tun_pkg::CoordWidth,
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::NormalFracBits,
  localparam int unsigned InW = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // first_x, first_y, first_z, pivot_x, pivot_y, pivot_z, third_x, third_y, third_z
  input  logic [InW-1:0] s_axis_tdata_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // normal_x, normal_y, normal_z
  output logic [3*tun_pkg::OutWidth-1:0] m_axis_tdata_o,
  // degenerate
  output logic           m_axis_tuser_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned NL  = tun_pkg::NumLanes;
  localparam int unsigned OW  = tun_pkg::OutWidth;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned CXW = PW + 1;
  localparam int unsigned MW  = PW;
  localparam int unsigned H   = DW;
  localparam int unsigned SQW = 2 * MW;
  localparam int unsigned SW  = SQW + 2;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned RW  = SW + 2 * F + 2;
  localparam int unsigned QSW = SW + F + 2;
  localparam int unsigned VW  = QW + OW + 1;

  localparam logic signed [VW-1:0] SatHi = VW'(2 ** (OW - 1) - 1);
  localparam logic signed [VW-1:0] SatLo = -(VW'(2 ** (OW - 1)));

  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // stage 1: edges
  tun_pkg::ctl_t                       ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  logic signed [CW-1:0]                crd [9];
  logic signed [NL-1:0][DW-1:0]        ea_d, eb_d, ea_q, eb_q;
  // stage 2: products
  logic signed [5:0][PW-1:0]           pr_d, pr_q;
  // stage 3: cross product magnitudes
  logic [NL-1:0][MW-1:0]               mag_d, mag_q;
  logic [NL-1:0]                       neg_d;
  logic signed [NL-1:0][CXW-1:0]       cx;
  // stage 4: partial squares
  logic [NL-1:0][PW-1:0]               hh_q, hl_q, ll_q;
  // stage 5: squares
  logic [NL-1:0][SQW-1:0]              sq_q;
  // stage 6: sum and search start
  logic [SW-1:0]                       sum_d;

  tun_pkg::ctl_t                       st_ctl [F+2];
  logic [SW-1:0]                       st_sum [F+2];
  logic [NL-1:0][RW-1:0]               st_rem [F+2];
  logic [NL-1:0][QSW-1:0]              st_acc [F+2];
  logic [NL-1:0][QW-1:0]               st_quo [F+2];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = s_axis_tdata_i[i*CW +: CW];
    end
    for (int l = 0; l < NL; l++) begin
      ea_d[l] = DW'(crd[6+l]) - DW'(crd[3+l]);
      eb_d[l] = DW'(crd[l]) - DW'(crd[3+l]);
    end
    // lane selects of packed arrays are unsigned; multiply as signed
    pr_d[0] = PW'($signed(ea_q[1]) * $signed(eb_q[2]));
    pr_d[1] = PW'($signed(ea_q[2]) * $signed(eb_q[1]));
    pr_d[2] = PW'($signed(ea_q[2]) * $signed(eb_q[0]));
    pr_d[3] = PW'($signed(ea_q[0]) * $signed(eb_q[2]));
    pr_d[4] = PW'($signed(ea_q[0]) * $signed(eb_q[1]));
    pr_d[5] = PW'($signed(ea_q[1]) * $signed(eb_q[0]));
    for (int l = 0; l < NL; l++) begin
      cx[l]    = CXW'($signed(pr_q[2*l])) - CXW'($signed(pr_q[2*l+1]));
      neg_d[l] = cx[l][CXW-1];
      mag_d[l] = neg_d[l] ? MW'(-cx[l]) : MW'(cx[l]);
    end
    sum_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else if (en) begin
      ctl1_q <= '{valid: s_axis_tvalid_i, degen: 1'b0, neg: '0};
      ctl2_q <= ctl1_q;
      ctl3_q <= '{valid: ctl2_q.valid, degen: 1'b0, neg: neg_d};
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= '{valid: ctl5_q.valid, degen: (sum_d == '0), neg: ctl5_q.neg};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ea_q  <= ea_d;
      eb_q  <= eb_d;
      pr_q  <= pr_d;
      mag_q <= mag_d;
      for (int l = 0; l < NL; l++) begin
        hh_q[l] <= mag_q[l][MW-1:H] * mag_q[l][MW-1:H];
        hl_q[l] <= mag_q[l][MW-1:H] * mag_q[l][H-1:0];
        ll_q[l] <= mag_q[l][H-1:0] * mag_q[l][H-1:0];
        sq_q[l] <= (SQW'(hh_q[l]) << (2 * H)) + (SQW'(hl_q[l]) << (H + 1))
                   + SQW'(ll_q[l]);
        st_rem[0][l] <= RW'(sq_q[l]) << (2 * F);
      end
      st_sum[0] <= sum_d;
    end
  end

  assign st_ctl[0] = ctl6_q;
  assign st_acc[0] = '0;
  assign st_quo[0] = '0;

  for (genvar j = 0; j <= F; j++) begin : g_step
    tun_norm_step #(
      .SW (SW),
      .QW (QW),
      .RW (RW),
      .QSW(QSW),
      .K  (F - j)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (st_ctl[j]),
      .sum_i (st_sum[j]),
      .rem_i (st_rem[j]),
      .acc_i (st_acc[j]),
      .quo_i (st_quo[j]),
      .ctl_o (st_ctl[j+1]),
      .sum_o (st_sum[j+1]),
      .rem_o (st_rem[j+1]),
      .acc_o (st_acc[j+1]),
      .quo_o (st_quo[j+1])
    );
  end

  // output stage: sign, saturate, force zero on a degenerate triangle
  logic                  out_vld_q;
  logic                  out_deg_q;
  logic [NL-1:0][OW-1:0] out_d, out_q;
  logic signed [NL-1:0][VW-1:0] sv;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sv[l] = st_ctl[F+1].neg[l] ? -VW'(st_quo[F+1][l]) : VW'(st_quo[F+1][l]);
      if (st_ctl[F+1].degen) begin
        out_d[l] = '0;
      end else if ($signed(sv[l]) > SatHi) begin
        out_d[l] = {1'b0, {(OW-1){1'b1}}};
      end else if ($signed(sv[l]) < SatLo) begin
        out_d[l] = {1'b1, {(OW-1){1'b0}}};
      end else begin
        out_d[l] = sv[l][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= st_ctl[F+1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q     <= out_d;
      out_deg_q <= st_ctl[F+1].degen;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = out_deg_q;

endmodule

// ----- tb/triangle_unit_normal_checker.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal_checker
// Watches both streams of the unit normal block and checks every normal.
// Each accepted triangle is turned into an expected normal by an exact
// integer computation. Each accepted output transaction is compared field by
// field with the oldest expected normal.
// ----------------------------------------------------------------------------
module triangle_unit_normal_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [143:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [47:0]  m_data_i,
  input  logic         m_user_i,
  output int           errors_o,
  output int           pending_o
);

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  normal_t normals_q[$];

  function automatic logic signed [15:0] coord_at(logic [143:0] d, int idx);
    logic [tun_pkg::CoordWidth-1:0] raw;
    raw = d[idx*16 +: tun_pkg::CoordWidth];
    return 16'(signed'(raw));
  endfunction

  // largest q in [0, 2^F] with q^2 * sumsq <= c^2 * 2^(2F)
  function automatic logic [31:0] unit_mag(logic [63:0] cmag, logic [127:0] sumsq);
    logic [127:0] target;
    logic [63:0]  lo, hi, mid;
    target = (128'(cmag) * 128'(cmag)) << (2 * tun_pkg::NormalFracBits);
    lo = 0;
    hi = 64'd1 << tun_pkg::NormalFracBits;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (128'(mid * mid) * sumsq <= target) lo = mid;
      else hi = mid - 1;
    end
    return 32'(lo);
  endfunction

  function automatic logic signed [15:0] clamp_out(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic normal_t face_normal(logic [143:0] d);
    normal_t     n;
    longint      ex, ey, ez, fx, fy, fz;
    longint      c[3];
    logic [127:0] sumsq;
    longint      q;
    ex = coord_at(d, 6) - coord_at(d, 3);
    ey = coord_at(d, 7) - coord_at(d, 4);
    ez = coord_at(d, 8) - coord_at(d, 5);
    fx = coord_at(d, 0) - coord_at(d, 3);
    fy = coord_at(d, 1) - coord_at(d, 4);
    fz = coord_at(d, 2) - coord_at(d, 5);
    c[0] = ey * fz - ez * fy;
    c[1] = ez * fx - ex * fz;
    c[2] = ex * fy - ey * fx;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      sumsq += 128'(c[i] < 0 ? -c[i] : c[i]) * 128'(c[i] < 0 ? -c[i] : c[i]);
    end
    n = '{0, 0, 0, 1'b1};
    if (sumsq == 0) return n;
    n.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = longint'(unit_mag(64'(c[i] < 0 ? -c[i] : c[i]), sumsq));
      if (c[i] < 0) q = -q;
      case (i)
        0: n.nx = clamp_out(q);
        1: n.ny = clamp_out(q);
        default: n.nz = clamp_out(q);
      endcase
    end
    return n;
  endfunction

  assign pending_o = normals_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    normal_t want;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (s_valid_i && s_ready_i) normals_q.push_back(face_normal(s_data_i));
      if (m_valid_i && m_ready_i) begin
        if (normals_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected normal transaction %h", m_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = normals_q.pop_front();
          if (m_data_i[15:0] !== want.nx || m_data_i[31:16] !== want.ny ||
              m_data_i[47:32] !== want.nz || m_user_i !== want.degen) begin
            if (errors_o < 10)
              $display("normal mismatch: exp %0d %0d %0d degen %b, got %0d %0d %0d degen %b",
                       want.nx, want.ny, want.nz, want.degen,
                       $signed(m_data_i[15:0]), $signed(m_data_i[31:16]),
                       $signed(m_data_i[47:32]), m_user_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the triangle unit normal block.
// Sends directed triangles (extremes, degenerate and axis-aligned cases) and
// then random ones with random gaps and receiver stalls; the checker predicts
// and compares every normal.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NumRandom = 1500;
  localparam int IdleLimit = 5000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_valid;
  logic         s_ready;
  logic [143:0] s_data;
  logic         m_valid;
  logic         m_ready;
  logic [47:0]  m_data;
  logic         m_user;
  int           errors;
  int           pending;
  int           sent;
  int           idle_cycles;

  triangle_unit_normal_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  triangle_unit_normal_checker i_checker (
    .clk_i, .rst_ni,
    .s_valid_i (s_valid), .s_ready_i (s_ready), .s_data_i (s_data),
    .m_valid_i (m_valid), .m_ready_i (m_ready), .m_data_i (m_data),
    .m_user_i  (m_user),
    .errors_o  (errors), .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one triangle, hold until the transaction completes
  task automatic send_triangle(logic [143:0] tri_data);
    int gap;
    s_data  = tri_data;
    s_valid = 1'b1;
    do @(posedge clk_i); while (!s_ready);
    sent++;
    @(negedge clk_i);
    gap = gap_len();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic [143:0] pack_tri(int v0x, int v0y, int v0z, int v1x, int v1y,
                                            int v1z, int v2x, int v2y, int v2z);
    return {16'(v2z), 16'(v2y), 16'(v2x), 16'(v1z), 16'(v1y), 16'(v1x),
            16'(v0z), 16'(v0y), 16'(v0x)};
  endfunction

  function automatic logic [143:0] random_tri();
    logic [143:0] d;
    int           kind;
    int           span;
    for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'($urandom);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // small coordinates: frequent collinear and degenerate triangles
      span = $urandom_range(1, 3);
      for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'($urandom_range(0, 2 * span) - span);
    end else if (kind == 1) begin
      d[0 +: 48] = d[48 +: 48];
    end else if (kind == 2) begin
      d[96 +: 48] = d[48 +: 48];
    end else if (kind == 3) begin
      // medium range coordinates
      for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'($urandom_range(0, 2000) - 1000);
    end
    return d;
  endfunction

  // receiver: random stalls plus one long hold-off while the sender keeps going
  initial begin
    int  hold;
    bit  held;
    m_ready = 1'b0;
    held    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sent >= 300) begin
        held    = 1'b1;
        m_ready <= 1'b0;
        hold    = 0;
        while (hold < 200) begin
          @(negedge clk_i);
          hold++;
        end
        m_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL triangle_unit_normal_unit");
        $finish;
      end
    end
  end

  initial begin
    s_valid   = 1'b0;
    s_data    = '0;
    sent      = 0;
    rst_ni    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_triangle(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(pack_tri(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(0, 1, 0, 0, 0, 0, 1, 0, 0));
    send_triangle(pack_tri(0, 0, 1, 0, 0, 0, 1, 0, 0));
    send_triangle(pack_tri(0, 1, 0, 0, 0, 0, 0, 0, 1));
    send_triangle(pack_tri(1, 1, 1, 0, 0, 0, 2, 2, 2));
    send_triangle(pack_tri(32767, -32768, 32767, -32768, 32767, -32768,
                           32767, 32767, -32768));
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, 32767, -32768));
    send_triangle(pack_tri(32767, 0, 0, -32768, -32768, -32768, 0, 32767, 0));
    send_triangle(pack_tri(-32768, 0, 0, 32767, 32767, 32767, 0, 0, -32768));
    send_triangle(pack_tri(32767, 32767, 32767, 32767, 32767, 32767, 1, 2, 3));
    send_triangle(pack_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_triangle(pack_tri(5, 7, -3, 5, 7, -3, 9, -2, 4));
    send_triangle(pack_tri(3, 0, 0, 0, 0, 0, 0, 4, 0));
    send_triangle(pack_tri(1, 1, 0, 0, 0, 0, -1, 1, 0));
    send_triangle(pack_tri(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 1));

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 700) begin
        // drain the pipeline before continuing
        s_valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      send_triangle(random_tri());
    end
    s_valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS triangle_unit_normal_unit");
    end else begin
      $display("FAIL triangle_unit_normal_unit");
    end
    $finish;
  end

endmodule

// ----- triangle_unit_normal_unit.f -----
rtl/core/tun_pkg.sv
rtl/core/tun_norm_step.sv
rtl/core/triangle_unit_normal_unit.sv
tb/triangle_unit_normal_checker.sv
tb/testbench.sv
